// ===== hw/rtl/slc_pkg.sv =====
package slc_pkg;

  // Fixed field widths of the access, result and configuration ports.
  localparam int unsigned OpW        = 2;
  localparam int unsigned OutcomeW   = 2;
  localparam int unsigned CntW       = 32;
  localparam int unsigned StampW     = 32;
  localparam int unsigned SetBitsW   = 3;
  localparam int unsigned BlockBitsW = 5;
  localparam int unsigned WaysW      = 4;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 5;

  typedef enum logic [OpW-1:0] {
    OP_LOAD   = 2'd0,
    OP_STORE  = 2'd1,
    OP_MODIFY = 2'd2
  } op_e;

  typedef enum logic [OutcomeW-1:0] {
    OUT_HIT   = 2'd0,
    OUT_MISS  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_e;

  localparam logic [CfgIdxW-1:0] REG_SET_BITS   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_BLOCK_BITS = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_WAYS_USED  = 2'd2;

  localparam logic [SetBitsW-1:0]   SET_BITS_RST   = 3'd4;
  localparam logic [BlockBitsW-1:0] BLOCK_BITS_RST = 5'd4;
  localparam logic [WaysW-1:0]      WAYS_USED_RST  = 4'd1;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] x);
    sat_inc = (x == '1) ? x : x + CntW'(1);
  endfunction

endpackage

// ===== hw/rtl/slc_ram.sv =====
module slc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AddrW-1:0]      waddr_i,
  input  logic [Width-1:0]      wdata_i,
  input  logic                  re_i,
  input  logic [AddrW-1:0]      raddr_i,
  output logic [Width-1:0]      rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/slc_queue.sv =====
module slc_queue #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             valid_o,
  output logic [Width-1:0] data_o
);

  logic [Width-1:0] slot_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== hw/rtl/slc_front.sv =====
module slc_front #(
  parameter int unsigned MaxSetBits = 6,
  parameter int unsigned MaxWays    = 8,
  parameter int unsigned AddrBits   = 64,
  parameter int unsigned SetW       = 6,
  parameter int unsigned NwW        = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [slc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [slc_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                           start,
  output logic                           busy,
  input  logic [slc_pkg::OpW-1:0]        op_i,
  input  logic [63:0]                    address_i,
  input  logic                           q_full_i,
  input  logic                           clearing_i,
  output logic                           push_o,
  output logic                           push_modify_o,
  output logic [SetW-1:0]                push_set_o,
  output logic [AddrBits-1:0]            push_tag_o,
  output logic [NwW-1:0]                 nw_o
);

  logic [slc_pkg::SetBitsW-1:0]   set_bits_q;
  logic [slc_pkg::BlockBitsW-1:0] block_bits_q;
  logic [slc_pkg::WaysW-1:0]      ways_used_q;

  logic [3:0]          sb;
  logic [5:0]          tag_sh;
  logic [AddrBits-1:0] addr;
  logic [AddrBits-1:0] addr_sh;
  logic [SetW:0]       set_lim;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q   <= slc_pkg::SET_BITS_RST;
      block_bits_q <= slc_pkg::BLOCK_BITS_RST;
      ways_used_q  <= slc_pkg::WAYS_USED_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        slc_pkg::REG_SET_BITS:   set_bits_q   <= cfg_data_i[slc_pkg::SetBitsW-1:0];
        slc_pkg::REG_BLOCK_BITS: block_bits_q <= cfg_data_i;
        slc_pkg::REG_WAYS_USED:  ways_used_q  <= cfg_data_i[slc_pkg::WaysW-1:0];
        default: ;
      endcase
    end
  end

  // Associativity of zero behaves as one; oversized values clamp to the built ways.
  always_comb begin
    if (ways_used_q == '0) begin
      nw_o = NwW'(1);
    end else if (32'(ways_used_q) > MaxWays) begin
      nw_o = NwW'(MaxWays);
    end else begin
      nw_o = NwW'(ways_used_q);
    end
  end

  assign sb      = (32'(set_bits_q) > MaxSetBits) ? 4'(MaxSetBits) : 4'(set_bits_q);
  assign tag_sh  = 6'(sb) + 6'(block_bits_q);
  assign addr    = address_i[AddrBits-1:0];
  assign addr_sh = addr >> block_bits_q;
  assign set_lim = (SetW + 1)'(1) << sb;

  assign busy          = q_full_i || clearing_i;
  assign push_o        = start && !busy;
  assign push_modify_o = (op_i == slc_pkg::OP_MODIFY);
  assign push_set_o    = addr_sh[SetW-1:0] & SetW'(set_lim - (SetW + 1)'(1));
  assign push_tag_o    = addr >> tag_sh;

endmodule

// ===== hw/rtl/slc_back.sv =====
module slc_back #(
  parameter int unsigned MaxSetBits = 6,
  parameter int unsigned MaxWays    = 8,
  parameter int unsigned AddrBits   = 64,
  parameter int unsigned SetW       = 6,
  parameter int unsigned NwW        = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            q_valid_i,
  input  logic                            q_modify_i,
  input  logic [SetW-1:0]                 q_set_i,
  input  logic [AddrBits-1:0]             q_tag_i,
  output logic                            q_pop_o,
  input  logic [NwW-1:0]                  nw_i,
  output logic                            clearing_o,
  output logic                            strobe_o,
  output logic [slc_pkg::OutcomeW-1:0]    outcome_o,
  output logic                            last_o,
  output logic [slc_pkg::CntW-1:0]        hit_total_o,
  output logic [slc_pkg::CntW-1:0]        miss_total_o,
  output logic [slc_pkg::CntW-1:0]        eviction_total_o
);

  localparam int unsigned Rows   = 1 << MaxSetBits;
  localparam int unsigned WayW   = AddrBits + slc_pkg::StampW + 1;
  localparam int unsigned RowW   = MaxWays * WayW;
  localparam int unsigned IdxW   = (MaxWays > 1) ? $clog2(MaxWays) : 1;
  localparam int unsigned Leaves = 1 << $clog2(MaxWays);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_SECOND
  } state_e;

  state_e                        state_q;
  logic [SetW-1:0]               clr_q;
  logic                          ent_modify_q;
  logic [SetW-1:0]               ent_set_q;
  logic [AddrBits-1:0]           ent_tag_q;
  logic [slc_pkg::StampW-1:0]    clock_q, cur_clk;
  logic [slc_pkg::CntW-1:0]      hits_q, misses_q, evictions_q;
  logic                          strobe_q, last_q;
  slc_pkg::outcome_e             outcome_q, outcome_d;

  logic                          ram_we, ram_re;
  logic [SetW-1:0]               ram_waddr;
  logic [RowW-1:0]               ram_wdata, rdata, new_row;

  logic                          w_valid [MaxWays];
  logic [AddrBits-1:0]           w_tag   [MaxWays];
  logic [slc_pkg::StampW-1:0]    w_stamp [MaxWays];
  logic                          w_match [MaxWays];
  logic                          w_inval [MaxWays];

  logic                          tr_en  [2*Leaves];
  logic [slc_pkg::StampW-1:0]    tr_age [2*Leaves];
  logic [IdxW-1:0]               tr_idx [2*Leaves];

  logic                          hit, has_inv;
  logic [IdxW-1:0]               hit_way, inv_way, sel_way;

  assign cur_clk = clock_q + slc_pkg::StampW'(1);

  // Each set is one memory row holding valid, stamp and tag of every way.
  always_comb begin
    for (int w = 0; w < MaxWays; w++) begin
      w_valid[w] = rdata[w*WayW];
      w_stamp[w] = rdata[w*WayW + 1 +: slc_pkg::StampW];
      w_tag[w]   = rdata[w*WayW + 1 + slc_pkg::StampW +: AddrBits];
      w_match[w] = (NwW'(w) < nw_i) && w_valid[w] && (w_tag[w] == ent_tag_q);
      w_inval[w] = (NwW'(w) < nw_i) && !w_valid[w];
    end
  end

  always_comb begin
    hit     = 1'b0;
    has_inv = 1'b0;
    hit_way = '0;
    inv_way = '0;
    for (int w = MaxWays - 1; w >= 0; w--) begin
      if (w_match[w]) begin
        hit     = 1'b1;
        hit_way = IdxW'(w);
      end
      if (w_inval[w]) begin
        has_inv = 1'b1;
        inv_way = IdxW'(w);
      end
    end
  end

  // Oldest way by a comparison tree; on equal ages the lower way wins.
  always_comb begin
    tr_en[0]  = 1'b0;
    tr_age[0] = '0;
    tr_idx[0] = '0;
    for (int i = 0; i < Leaves; i++) begin
      tr_idx[Leaves + i] = IdxW'(i);
      if (i < MaxWays) begin
        tr_en[Leaves + i]  = (NwW'(i) < nw_i);
        tr_age[Leaves + i] = cur_clk - w_stamp[i];
      end else begin
        tr_en[Leaves + i]  = 1'b0;
        tr_age[Leaves + i] = '0;
      end
    end
    for (int n = Leaves - 1; n >= 1; n--) begin
      if (tr_en[2*n+1] && (!tr_en[2*n] || (tr_age[2*n+1] > tr_age[2*n]))) begin
        tr_en[n]  = tr_en[2*n+1];
        tr_age[n] = tr_age[2*n+1];
        tr_idx[n] = tr_idx[2*n+1];
      end else begin
        tr_en[n]  = tr_en[2*n];
        tr_age[n] = tr_age[2*n];
        tr_idx[n] = tr_idx[2*n];
      end
    end
  end

  always_comb begin
    if (hit) begin
      sel_way   = hit_way;
      outcome_d = slc_pkg::OUT_HIT;
    end else if (has_inv) begin
      sel_way   = inv_way;
      outcome_d = slc_pkg::OUT_MISS;
    end else begin
      sel_way   = tr_idx[1];
      outcome_d = slc_pkg::OUT_EVICT;
    end
    new_row = rdata;
    new_row[32'(sel_way)*WayW +: WayW] = {ent_tag_q, cur_clk, 1'b1};
  end

  assign clearing_o = (state_q == ST_CLEAR);
  assign q_pop_o    = (state_q == ST_IDLE) && q_valid_i;
  assign ram_re     = q_pop_o;
  assign ram_we     = (state_q == ST_CLEAR) || (state_q == ST_LOOK);
  assign ram_waddr  = (state_q == ST_CLEAR) ? clr_q : ent_set_q;
  assign ram_wdata  = (state_q == ST_CLEAR) ? '0 : new_row;

  slc_ram #(
    .Width (RowW),
    .Depth (Rows)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (q_set_i),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      ent_modify_q <= q_modify_i;
      ent_set_q    <= q_set_i;
      ent_tag_q    <= q_tag_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      clock_q     <= '0;
      hits_q      <= '0;
      misses_q    <= '0;
      evictions_q <= '0;
      strobe_q    <= 1'b0;
      last_q      <= 1'b0;
      outcome_q   <= slc_pkg::OUT_HIT;
    end else begin
      strobe_q <= 1'b0;
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + SetW'(1);
          if (clr_q == SetW'(Rows - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_valid_i) begin
            state_q <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          clock_q   <= cur_clk;
          strobe_q  <= 1'b1;
          outcome_q <= outcome_d;
          last_q    <= !ent_modify_q;
          if (hit) begin
            hits_q <= slc_pkg::sat_inc(hits_q);
          end else begin
            misses_q <= slc_pkg::sat_inc(misses_q);
            if (!has_inv) begin
              evictions_q <= slc_pkg::sat_inc(evictions_q);
            end
          end
          state_q <= ent_modify_q ? ST_SECOND : ST_IDLE;
        end
        ST_SECOND: begin
          // The line touched by the first access now holds the tag at the same stamp.
          hits_q    <= slc_pkg::sat_inc(hits_q);
          strobe_q  <= 1'b1;
          outcome_q <= slc_pkg::OUT_HIT;
          last_q    <= 1'b1;
          state_q   <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign strobe_o         = strobe_q;
  assign outcome_o        = outcome_q;
  assign last_o           = last_q;
  assign hit_total_o      = hits_q;
  assign miss_total_o     = misses_q;
  assign eviction_total_o = evictions_q;

endmodule

// ===== hw/rtl/set_assoc_lru_cache_sim.sv =====
// Set-associative cache model with LRU replacement. An access is taken when start is high
// and busy is low; a load or store yields one result and a modify two, each shown for a
// single cycle with result_strobe_o and cannot be held off, so the receiver must take it.
// A load or store occupies the lookup engine for the registered read of the set row and its
// write-back, and a modify also for a second step that records its hit; a two-entry queue
// in front lets start be accepted while earlier accesses are still in flight. After reset busy
// stays high while the valid bits of all 2^MAX_SET_BITS sets are cleared, one set per cycle.
module set_assoc_lru_cache_sim #(
  parameter int unsigned MAX_SET_BITS = 6,
  parameter int unsigned MAX_WAYS     = 8,
  parameter int unsigned ADDR_BITS    = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [slc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [slc_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                           start,
  output logic                           busy,
  input  logic [slc_pkg::OpW-1:0]        op_i,
  input  logic [63:0]                    address_i,
  output logic                           result_strobe_o,
  output logic [slc_pkg::OutcomeW-1:0]   outcome_o,
  output logic                           last_o,
  output logic [slc_pkg::CntW-1:0]       hit_total_o,
  output logic [slc_pkg::CntW-1:0]       miss_total_o,
  output logic [slc_pkg::CntW-1:0]       eviction_total_o
);

  localparam int unsigned SetW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int unsigned NwW  = $clog2(MAX_WAYS + 1);
  localparam int unsigned EntW = 1 + SetW + ADDR_BITS;

  logic                 push, push_modify;
  logic [SetW-1:0]      push_set;
  logic [ADDR_BITS-1:0] push_tag;
  logic [NwW-1:0]       nw;
  logic                 q_full, q_valid, q_pop, clearing;
  logic [EntW-1:0]      q_data;

  slc_front #(
    .MaxSetBits (MAX_SET_BITS),
    .MaxWays    (MAX_WAYS),
    .AddrBits   (ADDR_BITS),
    .SetW       (SetW),
    .NwW        (NwW)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .start         (start),
    .busy          (busy),
    .op_i          (op_i),
    .address_i     (address_i),
    .q_full_i      (q_full),
    .clearing_i    (clearing),
    .push_o        (push),
    .push_modify_o (push_modify),
    .push_set_o    (push_set),
    .push_tag_o    (push_tag),
    .nw_o          (nw)
  );

  slc_queue #(
    .Width (EntW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({push_modify, push_set, push_tag}),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  slc_back #(
    .MaxSetBits (MAX_SET_BITS),
    .MaxWays    (MAX_WAYS),
    .AddrBits   (ADDR_BITS),
    .SetW       (SetW),
    .NwW        (NwW)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_modify_i       (q_data[EntW-1]),
    .q_set_i          (q_data[ADDR_BITS +: SetW]),
    .q_tag_i          (q_data[ADDR_BITS-1:0]),
    .q_pop_o          (q_pop),
    .nw_i             (nw),
    .clearing_o       (clearing),
    .strobe_o         (result_strobe_o),
    .outcome_o        (outcome_o),
    .last_o           (last_o),
    .hit_total_o      (hit_total_o),
    .miss_total_o     (miss_total_o),
    .eviction_total_o (eviction_total_o)
  );

endmodule
